// ----- rtl/bdqe_pkg.sv -----
`timescale 1ns / 1ps

package bdqe_pkg;

  localparam int HistoryDepthDefault = 4;

  localparam logic [3:0] STEPS_PER_DETENT_RESET = 4'd4;

  localparam logic [2:0] EV_NONE          = 3'd0;
  localparam logic [2:0] EV_POWER_PRESS   = 3'd1;
  localparam logic [2:0] EV_POWER_RELEASE = 3'd2;
  localparam logic [2:0] EV_SELECT        = 3'd3;
  localparam logic [2:0] EV_VOL_UP        = 3'd4;
  localparam logic [2:0] EV_VOL_DOWN      = 3'd5;
  localparam logic [2:0] EV_CCW           = 3'd6;
  localparam logic [2:0] EV_CW            = 3'd7;

  localparam logic [1:0] PHASE_RESET = 2'b11;

  typedef struct packed {
    logic press;
    logic release_ev;
  } deb_event_t;

  // Gray phase pair to its place on the counter-clockwise cycle 00, 01, 11, 10.
  function automatic logic [1:0] phase_position(input logic [1:0] ph);
    logic [1:0] pos;
    begin
      case (ph)
        2'b00:   pos = 2'd0;
        2'b01:   pos = 2'd1;
        2'b11:   pos = 2'd2;
        2'b10:   pos = 2'd3;
        default: pos = 2'd0;
      endcase
      return pos;
    end
  endfunction

endpackage

// ----- rtl/bdqe_debounce.sv -----
`timescale 1ns / 1ps

module bdqe_debounce #(
  parameter int HISTORY_DEPTH = bdqe_pkg::HistoryDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_en,
  input  logic                  sample,
  output bdqe_pkg::deb_event_t  ev
);
  import bdqe_pkg::*;

  logic [HISTORY_DEPTH-1:0] hist;
  logic [HISTORY_DEPTH-1:0] hist_next;
  logic                     level;

  assign hist_next = {hist[HISTORY_DEPTH-2:0], sample};

  // The level is 1 while released; a full run of one value flips it once.
  assign ev.press      = (hist_next == '0) && level;
  assign ev.release_ev = (hist_next == '1) && !level;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= '1;
      level <= 1'b1;
    end else if (sample_en) begin
      hist <= hist_next;
      if (ev.press) begin
        level <= 1'b0;
      end else if (ev.release_ev) begin
        level <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/button_debounce_and_quadrature_events.sv -----
`timescale 1ns / 1ps

// Each accepted input beat is one sample tick of four active-low buttons and
// the two encoder phases, and it yields exactly one output beat carrying an
// event code (zero when nothing happened). A button reports a press once its
// last HISTORY_DEPTH samples are all low; only the power button also reports
// a release, once its samples are all high again. Single quadrature steps move
// a signed counter, and reaching plus or minus steps_per_detent clears it and
// reports a rotation; double jumps only update the stored phase. The very
// first tick after reset only loads the phase. Rotation wins over volume
// down, volume up, select and power when several happen on one tick. An input
// beat is taken every clock cycle while the output register is empty or being
// drained; the result is registered and appears in the cycle after its input
// beat. steps_per_detent may be written only while no beat is in flight.
module button_debounce_and_quadrature_events #(
  parameter int HISTORY_DEPTH = bdqe_pkg::HistoryDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       power_button_n,
  input  logic       select_button_n,
  input  logic       vol_up_button_n,
  input  logic       vol_down_button_n,
  input  logic       phase_a,
  input  logic       phase_b,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_code
);
  import bdqe_pkg::*;

  logic              accept;
  logic [3:0]        steps_per_detent;
  deb_event_t        power_ev;
  deb_event_t        select_ev;
  deb_event_t        vol_up_ev;
  deb_event_t        vol_down_ev;
  logic [1:0]        phase;
  logic [1:0]        last_phase;
  logic              phase_primed;
  logic signed [4:0] step_count;
  logic signed [4:0] step_count_next;
  logic signed [5:0] count_inc;
  logic signed [5:0] count_dec;
  logic signed [5:0] spd_pos;
  logic signed [5:0] spd_neg;
  logic [1:0]        delta;
  logic              ccw_hit;
  logic              cw_hit;
  logic [2:0]        event_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_detent <= STEPS_PER_DETENT_RESET;
    end else if (cfg_write) begin
      steps_per_detent <= cfg_data;
    end
  end

  bdqe_debounce #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_power (
    .clk(clk), .rst(rst), .sample_en(accept), .sample(power_button_n), .ev(power_ev)
  );
  bdqe_debounce #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_select (
    .clk(clk), .rst(rst), .sample_en(accept), .sample(select_button_n), .ev(select_ev)
  );
  bdqe_debounce #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_vol_up (
    .clk(clk), .rst(rst), .sample_en(accept), .sample(vol_up_button_n), .ev(vol_up_ev)
  );
  bdqe_debounce #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_vol_down (
    .clk(clk), .rst(rst), .sample_en(accept), .sample(vol_down_button_n),
    .ev(vol_down_ev)
  );

  assign phase     = {phase_a, phase_b};
  assign delta     = phase_position(phase) - phase_position(last_phase);
  assign count_inc = {step_count[4], step_count} + 6'sd1;
  assign count_dec = {step_count[4], step_count} - 6'sd1;
  assign spd_pos   = $signed({2'b00, steps_per_detent});
  assign spd_neg   = -spd_pos;
  assign ccw_hit   = phase_primed && (phase != last_phase) && (delta == 2'd1) &&
                     (count_inc >= spd_pos);
  assign cw_hit    = phase_primed && (phase != last_phase) && (delta == 2'd3) &&
                     (count_dec <= spd_neg);

  always_comb begin
    step_count_next = step_count;
    if (phase_primed && (phase != last_phase)) begin
      if (delta == 2'd1) begin
        step_count_next = ccw_hit ? 5'sd0 : count_inc[4:0];
      end else if (delta == 2'd3) begin
        step_count_next = cw_hit ? 5'sd0 : count_dec[4:0];
      end
    end
  end

  always_comb begin
    if (cw_hit) begin
      event_next = EV_CW;
    end else if (ccw_hit) begin
      event_next = EV_CCW;
    end else if (vol_down_ev.press) begin
      event_next = EV_VOL_DOWN;
    end else if (vol_up_ev.press) begin
      event_next = EV_VOL_UP;
    end else if (select_ev.press) begin
      event_next = EV_SELECT;
    end else if (power_ev.press) begin
      event_next = EV_POWER_PRESS;
    end else if (power_ev.release_ev) begin
      event_next = EV_POWER_RELEASE;
    end else begin
      event_next = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase   <= PHASE_RESET;
      phase_primed <= 1'b0;
      step_count   <= 5'sd0;
    end else if (accept) begin
      last_phase   <= phase;
      phase_primed <= 1'b1;
      step_count   <= step_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_code <= event_next;
    end
  end

endmodule
